/* hdl/ccrc_pkg.sv */
// Package with the shared types and constants of the control chart rule checker.
`timescale 1ns / 1ps
package ccrc_pkg;

  // Width of the configuration registers and of the deviation output.
  localparam int CfgW          = 16;
  localparam int DevOutW       = 17;
  localparam int SampleBitsDef = 16;

  // Number of entries in the history window, the newest entry included.
  localparam int HistDepth = 8;

  // Windows and hit counts of the two counting rules.
  localparam int TwoWin   = 3;
  localparam int TwoNeed  = 2;
  localparam int FourWin  = 5;
  localparam int FourNeed = 4;

  // Configuration register indexes.
  localparam int CfgIdxW = 2;
  typedef enum logic [CfgIdxW-1:0] {
    RegCenter = 2'd0,
    RegSpread = 2'd1
  } cfg_reg_e;

  // Zone flags of one item; up0 is the least significant bit.
  typedef struct packed {
    logic dn2;
    logic up2;
    logic dn1;
    logic up1;
    logic dn0;
    logic up0;
  } zone_t;

  // Contents of one history cell: the zone flags and whether the entry holds an item.
  typedef struct packed {
    logic  filled;
    zone_t zone;
  } cell_t;

  // Result held in the output register.
  typedef struct packed {
    logic [DevOutW-1:0] deviation;
    logic               beyond_three;
    logic               two_of_three;
    logic               four_of_five;
    logic               eight_one_side;
  } result_t;

endpackage

/* hdl/ccrc_zone.sv */
// Deviation from the centre line and its classification into sigma zones.
`timescale 1ns / 1ps
module ccrc_zone import ccrc_pkg::*; #(
  parameter int SampleBits = SampleBitsDef
) (
  input  logic signed [SampleBits-1:0] sample_i,
  input  logic signed [CfgW-1:0]       center_i,
  input  logic        [CfgW-1:0]       spread_i,
  output logic        [DevOutW-1:0]    deviation_o,
  output zone_t                        zone_o,
  output logic                         beyond_three_o
);

  // The compare width holds the full deviation and three times the spread.
  localparam int DevW = ((SampleBits > CfgW) ? SampleBits : CfgW) + 1;
  localparam int CmpW = DevW + 2;

  logic signed [CmpW-1:0] smp_ext;
  logic signed [CmpW-1:0] ctr_ext;
  logic signed [CmpW-1:0] dev;
  logic signed [CmpW-1:0] sg1;
  logic signed [CmpW-1:0] sg2;
  logic signed [CmpW-1:0] sg3;

  // A spread of zero is taken as one; the multiples are formed by shift and add.
  assign sg1 = (spread_i == '0) ? CmpW'(1) : signed'(CmpW'(spread_i));
  assign sg2 = sg1 <<< 1;
  assign sg3 = sg1 + sg2;

  // Full-precision deviation of the sample from the centre line.
  assign smp_ext = CmpW'(sample_i);
  assign ctr_ext = CmpW'(center_i);
  assign dev     = smp_ext - ctr_ext;

  assign deviation_o = dev[DevOutW-1:0];

  // Every compare is strict, so a point exactly on a limit is not beyond it.
  assign zone_o.up0 = dev > CmpW'(0);
  assign zone_o.dn0 = dev < CmpW'(0);
  assign zone_o.up1 = dev > sg1;
  assign zone_o.dn1 = dev < -sg1;
  assign zone_o.up2 = dev > sg2;
  assign zone_o.dn2 = dev < -sg2;

  assign beyond_three_o = (dev > sg3) || (dev < -sg3);

endmodule

/* hdl/ccrc_cell.sv */
// One history cell: holds the zone flags of one past item and passes them on at each shift.
`timescale 1ns / 1ps
module ccrc_cell import ccrc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  shift_i,
  input  cell_t prev_i,
  output cell_t cell_o
);

  cell_t cell_q;
  cell_t cell_d;

  // Take the neighbour's contents whenever an item enters the chain.
  assign cell_d = shift_i ? prev_i : cell_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

/* hdl/control_chart_rule_checker.sv */
// Top level of the control chart rule checker.
`timescale 1ns / 1ps
// Checks each signed sample against the four Western Electric rules, using the
// centre and sigma held in two configuration registers (index 0: centre, signed;
// index 1: sigma, unsigned, where zero acts as one). An item is classified, run
// through the rule windows and written to the output register in the cycle it is
// accepted, so the result is offered in the next cycle; one item is taken in every
// cycle as long as the output side keeps up, and the output register lets a new
// item in while the previous result is taken. Windows see the last eight items, the
// incoming one included; older ones sit in a shifting chain of cells that also note
// whether they hold an item, so a windowed rule only fires once enough items have
// been seen since reset. The deviation output is sample minus centre, not a z-score.
module control_chart_rule_checker import ccrc_pkg::*; #(
  parameter int SAMPLE_BITS = SampleBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration writes.
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CfgIdxW-1:0]           cfg_index_i,
  input  logic [CfgW-1:0]              cfg_data_i,
  // Sample items.
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  // Result items.
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [DevOutW-1:0]    deviation_o,
  output logic                         beyond_three_o,
  output logic                         two_of_three_o,
  output logic                         four_of_five_o,
  output logic                         eight_one_side_o,
  output logic                         no_alarm_o
);

  logic signed [CfgW-1:0] center_q;
  logic        [CfgW-1:0] spread_q;

  logic                   accept;
  logic [DevOutW-1:0]     dev;
  zone_t                  zone;
  logic                   beyond_three;

  cell_t                  head;
  cell_t                  cells [HistDepth-1];
  cell_t                  win   [HistDepth];

  logic [1:0]             n_up2;
  logic [1:0]             n_dn2;
  logic [2:0]             n_up1;
  logic [2:0]             n_dn1;
  logic                   all_up;
  logic                   all_dn;

  result_t                res_d;
  result_t                res_q;
  logic                   out_valid_d;
  logic                   out_valid_q;

  // Configuration registers; writes to unused indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= '0;
      spread_q <= CfgW'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegCenter: center_q <= cfg_data_i;
        RegSpread: spread_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A new item enters whenever the output register is free or being emptied.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Classification of the incoming sample.
  ccrc_zone #(
    .SampleBits (SAMPLE_BITS)
  ) u_zone (
    .sample_i       (sample_i),
    .center_i       (center_q),
    .spread_i       (spread_q),
    .deviation_o    (dev),
    .zone_o         (zone),
    .beyond_three_o (beyond_three)
  );

  assign head.filled = 1'b1;
  assign head.zone   = zone;

  // History chain; the rule windows look at the incoming item and the contents before the shift.
  // The newest entry is the incoming item itself, so seven cells hold the older ones.
  assign win[0] = head;

  for (genvar k = 0; k < HistDepth - 1; k++) begin : g_cell
    ccrc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (accept),
      .prev_i  ((k == 0) ? head : cells[(k == 0) ? 0 : k-1]),
      .cell_o  (cells[k])
    );
    assign win[k+1] = cells[k];
  end

  // Hit counts over the two counting windows and the one-side run.
  always_comb begin
    n_up2  = '0;
    n_dn2  = '0;
    n_up1  = '0;
    n_dn1  = '0;
    all_up = 1'b1;
    all_dn = 1'b1;
    for (int i = 0; i < TwoWin; i++) begin
      n_up2 = n_up2 + 2'(win[i].zone.up2);
      n_dn2 = n_dn2 + 2'(win[i].zone.dn2);
    end
    for (int i = 0; i < FourWin; i++) begin
      n_up1 = n_up1 + 3'(win[i].zone.up1);
      n_dn1 = n_dn1 + 3'(win[i].zone.dn1);
    end
    for (int i = 0; i < HistDepth; i++) begin
      all_up = all_up & win[i].zone.up0;
      all_dn = all_dn & win[i].zone.dn0;
    end
  end

  // A windowed rule counts only when the oldest entry of its window holds an item.
  assign res_d.deviation      = dev;
  assign res_d.beyond_three   = beyond_three;
  assign res_d.two_of_three   = win[TwoWin-1].filled &&
                                ((n_up2 >= 2'(TwoNeed)) || (n_dn2 >= 2'(TwoNeed)));
  assign res_d.four_of_five   = win[FourWin-1].filled &&
                                ((n_up1 >= 3'(FourNeed)) || (n_dn1 >= 3'(FourNeed)));
  assign res_d.eight_one_side = win[HistDepth-1].filled && (all_up || all_dn);

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign deviation_o      = res_q.deviation;
  assign beyond_three_o   = res_q.beyond_three;
  assign two_of_three_o   = res_q.two_of_three;
  assign four_of_five_o   = res_q.four_of_five;
  assign eight_one_side_o = res_q.eight_one_side;
  assign no_alarm_o       = !(res_q.beyond_three || res_q.two_of_three ||
                              res_q.four_of_five || res_q.eight_one_side);

endmodule
